// ===== rtl/core/slrs_pkg.sv =====
// shared types, constants and helpers of the soil layer runoff step
package slrs_pkg;

  localparam int unsigned LayerCount = 6;
  localparam logic [17:0] RAIN_CORR_Q16 = 18'd65536;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [19:0] SP_MAX = 20'd524288;
  localparam logic [2:0] LAST_LAYER = 3'(LayerCount - 1);
  localparam logic [2:0] LAST_STORE = 3'd4;

  typedef struct packed {
    logic [24:0] rain_depth;
    logic [24:0] pet_depth;
  } in_t;

  typedef struct packed {
    logic [28:0] actual_evap;
    logic [28:0] overland_flow;
    logic [28:0] drain_flow;
    logic [28:0] inter_flow;
    logic [28:0] shallow_flow;
    logic [28:0] deep_flow;
    logic [28:0] soil_moisture;
  } out_t;

  typedef enum logic [2:0] {
    CFG_EVAP_DECAY,
    CFG_QUICK_RUNOFF,
    CFG_DRAIN_FRAC,
    CFG_SOIL_OUTFLOW,
    CFG_SOIL_DEPTH,
    CFG_SURFACE_ROUTE,
    CFG_INTER_ROUTE,
    CFG_GW_ROUTE
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAP_DIV,
    OP_CAP_SET,
    OP_H_MUL,
    OP_H_DIV,
    OP_H_SET,
    OP_OVE_MUL,
    OP_OVE_SET,
    OP_FILL,
    OP_DRA_MUL,
    OP_DRA_SET,
    OP_S_MUL,
    OP_S_DIV,
    OP_S_SET,
    OP_PW_MUL,
    OP_PW_SET,
    OP_L1_MUL,
    OP_L1_SET,
    OP_L2_DIV,
    OP_L2_MUL,
    OP_L2_SET,
    OP_L3_MUL,
    OP_L3_SET,
    OP_EV_MUL,
    OP_EV_SET,
    OP_RT_MUL,
    OP_RT_SET,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [2:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic surplus;
    logic div_busy;
    logic out_free;
  } status_t;

  function automatic logic [16:0] sat_frac(input logic [16:0] f);
    sat_frac = (f > ONE_Q16) ? ONE_Q16 : f;
  endfunction

  function automatic logic [28:0] sat29(input logic [37:0] v);
    sat29 = (v > 38'h01FFFFFFF) ? 29'h1FFFFFFF : v[28:0];
  endfunction

endpackage

// ===== rtl/core/soil_layer_runoff_step.sv =====
// top level of the soil layer runoff step
// One item is one time step. After acceptance the sequencer sets the layer capacity,
// then runs either the surplus path (quick runoff ratio division, six-layer fill,
// outflow ratio division, powers, three leak passes, the second one scaling the
// ratio by a reciprocal of the layer number) or the deficit path (six
// evaporation steps, each a multiply then a set), then five routing steps.
// Products go through one shared 35x20 multiplier, the capacity and the
// per-layer ratio through constant reciprocal multipliers, and the two
// divisions by soil depth through one bit-serial divider. Either step
// loads its result only once the output register is free, so an output stall
// delays it; the input is ready again in the cycle after the result is loaded.
module soil_layer_runoff_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slrs_pkg::in_t       in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slrs_pkg::out_t      out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  slrs_pkg::cfg_idx_e  cfg_index_i,
  input  logic [28:0]         cfg_data_i
);
  import slrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  slrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/slrs_div.sv =====
// restoring divider, one quotient bit per cycle
module slrs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [51:0] num_i,
  input  logic [28:0] den_i,
  input  logic [5:0]  cnt_i,
  output logic        busy_o,
  output logic [51:0] quot_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [51:0] num_q;
  logic [51:0] quot_q;
  logic [28:0] rem_q;
  logic [28:0] den_q;
  logic [29:0] trial;
  logic        qbit;

  assign trial = {rem_q, num_q[51]};
  assign qbit  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cnt_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[50:0], 1'b0};
      rem_q  <= qbit ? 29'(trial - {1'b0, den_q}) : trial[28:0];
      quot_q <= {quot_q[50:0], qbit};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

endmodule

// ===== rtl/core/slrs_ctrl.sv =====
// sequencer for the layer, leak and routing passes
module slrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slrs_pkg::status_t status_i,
  output slrs_pkg::cmd_t    cmd_o
);
  import slrs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CAP_DIV, ST_CAP_WAIT, ST_CAP_SET,
    ST_H_MUL, ST_H_DIV, ST_H_WAIT, ST_H_SET,
    ST_OVE_MUL, ST_OVE_SET, ST_FILL, ST_DRA_MUL, ST_DRA_SET,
    ST_S_MUL, ST_S_DIV, ST_S_WAIT, ST_S_SET,
    ST_PW_MUL, ST_PW_SET, ST_L1_MUL, ST_L1_SET,
    ST_L2_DIV, ST_L2_WAIT, ST_L2_MUL, ST_L2_SET,
    ST_L3_MUL, ST_L3_SET, ST_EV_MUL, ST_EV_SET,
    ST_RT_MUL, ST_RT_SET, ST_FINISH
  } state_e;

  state_e     state_q;
  logic [2:0] idx_q;
  logic       last_layer;

  assign last_layer = idx_q == LAST_LAYER;
  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    cmd_o.idx = idx_q;
    case (state_q)
      ST_IDLE:    cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_CAP_DIV: cmd_o.op = OP_CAP_DIV;
      ST_CAP_SET: cmd_o.op = OP_CAP_SET;
      ST_H_MUL:   cmd_o.op = OP_H_MUL;
      ST_H_DIV:   cmd_o.op = OP_H_DIV;
      ST_H_SET:   cmd_o.op = OP_H_SET;
      ST_OVE_MUL: cmd_o.op = OP_OVE_MUL;
      ST_OVE_SET: cmd_o.op = OP_OVE_SET;
      ST_FILL:    cmd_o.op = OP_FILL;
      ST_DRA_MUL: cmd_o.op = OP_DRA_MUL;
      ST_DRA_SET: cmd_o.op = OP_DRA_SET;
      ST_S_MUL:   cmd_o.op = OP_S_MUL;
      ST_S_DIV:   cmd_o.op = OP_S_DIV;
      ST_S_SET:   cmd_o.op = OP_S_SET;
      ST_PW_MUL:  cmd_o.op = OP_PW_MUL;
      ST_PW_SET:  cmd_o.op = OP_PW_SET;
      ST_L1_MUL:  cmd_o.op = OP_L1_MUL;
      ST_L1_SET:  cmd_o.op = OP_L1_SET;
      ST_L2_DIV:  cmd_o.op = OP_L2_DIV;
      ST_L2_MUL:  cmd_o.op = OP_L2_MUL;
      ST_L2_SET:  cmd_o.op = OP_L2_SET;
      ST_L3_MUL:  cmd_o.op = OP_L3_MUL;
      ST_L3_SET:  cmd_o.op = OP_L3_SET;
      ST_EV_MUL:  cmd_o.op = OP_EV_MUL;
      ST_EV_SET:  cmd_o.op = OP_EV_SET;
      ST_RT_MUL:  cmd_o.op = OP_RT_MUL;
      ST_RT_SET:  cmd_o.op = OP_RT_SET;
      ST_FINISH:  cmd_o.op = status_i.out_free ? OP_FINISH : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE:     if (in_valid_i) state_q <= ST_CAP_DIV;
        ST_CAP_DIV:  state_q <= ST_CAP_WAIT;
        ST_CAP_WAIT: if (!status_i.div_busy) state_q <= ST_CAP_SET;
        ST_CAP_SET: begin
          idx_q   <= '0;
          state_q <= status_i.surplus ? ST_H_MUL : ST_EV_MUL;
        end
        ST_H_MUL:    state_q <= ST_H_DIV;
        ST_H_DIV:    state_q <= ST_H_WAIT;
        ST_H_WAIT:   if (!status_i.div_busy) state_q <= ST_H_SET;
        ST_H_SET:    state_q <= ST_OVE_MUL;
        ST_OVE_MUL:  state_q <= ST_OVE_SET;
        ST_OVE_SET:  state_q <= ST_FILL;
        ST_FILL: begin
          idx_q <= last_layer ? 3'd0 : idx_q + 3'd1;
          if (last_layer) state_q <= ST_DRA_MUL;
        end
        ST_DRA_MUL:  state_q <= ST_DRA_SET;
        ST_DRA_SET:  state_q <= ST_S_MUL;
        ST_S_MUL:    state_q <= ST_S_DIV;
        ST_S_DIV:    state_q <= ST_S_WAIT;
        ST_S_WAIT:   if (!status_i.div_busy) state_q <= ST_S_SET;
        ST_S_SET:    state_q <= ST_PW_MUL;
        ST_PW_MUL:   state_q <= ST_PW_SET;
        ST_PW_SET: begin
          idx_q   <= last_layer ? 3'd0 : idx_q + 3'd1;
          state_q <= last_layer ? ST_L1_MUL : ST_PW_MUL;
        end
        ST_L1_MUL:   state_q <= ST_L1_SET;
        ST_L1_SET: begin
          idx_q   <= last_layer ? 3'd0 : idx_q + 3'd1;
          state_q <= last_layer ? ST_L2_DIV : ST_L1_MUL;
        end
        ST_L2_DIV:   state_q <= ST_L2_WAIT;
        ST_L2_WAIT:  if (!status_i.div_busy) state_q <= ST_L2_MUL;
        ST_L2_MUL:   state_q <= ST_L2_SET;
        ST_L2_SET: begin
          idx_q   <= last_layer ? 3'd0 : idx_q + 3'd1;
          state_q <= last_layer ? ST_L3_MUL : ST_L2_DIV;
        end
        ST_L3_MUL:   state_q <= ST_L3_SET;
        ST_L3_SET: begin
          idx_q   <= last_layer ? 3'd0 : idx_q + 3'd1;
          state_q <= last_layer ? ST_RT_MUL : ST_L3_MUL;
        end
        ST_EV_MUL:   state_q <= ST_EV_SET;
        ST_EV_SET: begin
          idx_q   <= last_layer ? 3'd0 : idx_q + 3'd1;
          state_q <= last_layer ? ST_RT_MUL : ST_EV_MUL;
        end
        ST_RT_MUL:   state_q <= ST_RT_SET;
        ST_RT_SET: begin
          idx_q   <= (idx_q == LAST_STORE) ? 3'd0 : idx_q + 3'd1;
          state_q <= (idx_q == LAST_STORE) ? ST_FINISH : ST_RT_MUL;
        end
        ST_FINISH:   if (status_i.out_free) state_q <= ST_IDLE;
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_LAYER) else $error("layer index out of range");

endmodule

// ===== rtl/core/slrs_dp.sv =====
// datapath: layer and store registers, shared multiplier, divider, result register
module slrs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slrs_pkg::cmd_t      cmd_i,
  output slrs_pkg::status_t   status_o,
  input  slrs_pkg::in_t       in_i,
  input  logic                cfg_valid_i,
  input  slrs_pkg::cfg_idx_e  cfg_index_i,
  input  logic [28:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slrs_pkg::out_t      out_o
);
  import slrs_pkg::*;

  // configuration
  logic [16:0] cfg_c_q, cfg_h_q, cfg_d_q, cfg_s_q, cfg_surf_q, cfg_inter_q, cfg_gw_q;
  logic [28:0] cfg_depth_q;

  // state
  logic [31:0] lvl_q [LayerCount];
  logic [31:0] store_q [5];
  logic        out_valid_q;
  out_t        out_q;

  // per item working registers
  logic        surplus_q;
  logic [34:0] total_q;
  logic [34:0] excess_q;
  logic [24:0] deficit_q;
  logic [34:0] aeva_q;
  logic [26:0] cap_q;
  logic [16:0] hp_q;
  logic [19:0] sp_q;
  logic [19:0] spq_q;
  logic [19:0] pw_q [LayerCount];
  logic [26:0] to_ove_q;
  logic [34:0] to_dra_q;
  logic [36:0] to_int_q;
  logic [34:0] to_sgw_q, to_dgw_q;
  logic [31:0] rel_q [5];
  logic [54:0] prod_q;

  logic [34:0] mul_a;
  logic [19:0] mul_b;
  logic [42:0] rain_full;
  logic [26:0] rain_c;
  logic        rain_ge_pet;
  logic [34:0] lvl_sum;
  logic [31:0] lvl_cur;
  logic [19:0] pw_prev;
  logic [31:0] def_minus_lv;
  logic [28:0] zdiv;
  logic [59:0] cap_prod;
  logic [23:0] recip;
  logic [43:0] sp_recip;
  logic        div_start, div_busy;
  logic [51:0] div_num, div_quot;
  logic [28:0] div_den;
  logic [5:0]  div_cnt;
  logic signed [36:0] excess_s, space_s;
  logic [31:0] fill_lvl;
  logic [34:0] fill_excess;
  logic [35:0] leak;
  logic        leak_ok;
  logic [16:0] rt_frac;
  logic [36:0] rt_inflow;
  logic [37:0] rt_sum;
  logic [31:0] rt_new;
  logic        ev_cover;

  assign rain_full   = {18'b0, in_i.rain_depth} * {25'b0, RAIN_CORR_Q16};
  assign rain_c      = rain_full[42:16];
  assign rain_ge_pet = rain_c >= {2'b0, in_i.pet_depth};
  assign lvl_sum     = {3'b0, lvl_q[0]} + {3'b0, lvl_q[1]} + {3'b0, lvl_q[2]}
                     + {3'b0, lvl_q[3]} + {3'b0, lvl_q[4]} + {3'b0, lvl_q[5]};
  assign lvl_cur      = lvl_q[cmd_i.idx];
  assign pw_prev      = (cmd_i.idx == 3'd0) ? {3'b0, ONE_Q16} : pw_q[cmd_i.idx - 3'd1];
  assign def_minus_lv = {7'b0, deficit_q} - lvl_cur;
  assign zdiv         = (cfg_depth_q == '0) ? 29'd1 : cfg_depth_q;
  assign ev_cover     = lvl_cur >= {7'b0, deficit_q};

  // layer capacity: depth / 6 as (depth / 2) / 3 by reciprocal multiplication
  assign cap_prod = {32'b0, cfg_depth_q[28:1]} * {28'b0, 32'hAAAAAAAB};

  // reciprocals of one to six, scaled by 2^23, exact for 20-bit ratios
  always_comb begin
    case (cmd_i.idx)
      3'd0:    recip = 24'd8388608;
      3'd1:    recip = 24'd4194304;
      3'd2:    recip = 24'd2796203;
      3'd3:    recip = 24'd2097152;
      3'd4:    recip = 24'd1677722;
      default: recip = 24'd1398102;
    endcase
  end
  assign sp_recip = {24'b0, sp_q} * {20'b0, recip};

  // fill of one layer from the top
  assign excess_s = $signed({2'b0, excess_q});
  assign space_s  = $signed({10'b0, cap_q}) - $signed({5'b0, lvl_cur});
  always_comb begin
    if (excess_s <= space_s) begin
      fill_lvl    = lvl_cur + excess_q[31:0];
      fill_excess = '0;
    end else begin
      fill_lvl    = {5'b0, cap_q};
      fill_excess = 35'(excess_s - space_s);
    end
  end

  assign leak    = prod_q[51:16];
  assign leak_ok = leak < {4'b0, lvl_cur};

  // routing of one store
  always_comb begin
    case (cmd_i.idx)
      3'd0:    begin rt_frac = cfg_surf_q;  rt_inflow = {10'b0, to_ove_q}; end
      3'd1:    begin rt_frac = cfg_surf_q;  rt_inflow = {2'b0, to_dra_q};  end
      3'd2:    begin rt_frac = cfg_inter_q; rt_inflow = to_int_q;          end
      3'd3:    begin rt_frac = cfg_gw_q;    rt_inflow = {2'b0, to_sgw_q};  end
      default: begin rt_frac = cfg_gw_q;    rt_inflow = {2'b0, to_dgw_q};  end
    endcase
  end
  assign rt_sum = {6'b0, store_q[cmd_i.idx]} - {6'b0, prod_q[47:16]} + {1'b0, rt_inflow};
  assign rt_new = (rt_sum > 38'hFFFFFFFF) ? 32'hFFFFFFFF : rt_sum[31:0];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_H_MUL:   begin mul_a = total_q;  mul_b = {3'b0, sat_frac(cfg_h_q)}; end
      OP_OVE_MUL: begin mul_a = excess_q; mul_b = {3'b0, hp_q}; end
      OP_DRA_MUL: begin mul_a = excess_q; mul_b = {3'b0, sat_frac(cfg_d_q)}; end
      OP_S_MUL:   begin mul_a = total_q;  mul_b = {3'b0, sat_frac(cfg_s_q)}; end
      OP_PW_MUL:  begin mul_a = {15'b0, pw_prev}; mul_b = sp_q; end
      OP_L1_MUL:  begin mul_a = {3'b0, lvl_cur}; mul_b = pw_q[cmd_i.idx]; end
      OP_L2_MUL:  begin mul_a = {3'b0, lvl_cur}; mul_b = spq_q; end
      OP_L3_MUL:  begin mul_a = {3'b0, lvl_cur}; mul_b = pw_q[LAST_LAYER - cmd_i.idx]; end
      OP_EV_MUL:  begin
        mul_a = {10'b0, def_minus_lv[24:0]};
        mul_b = {3'b0, sat_frac(cfg_c_q)};
      end
      OP_RT_MUL:  begin mul_a = {3'b0, store_q[cmd_i.idx]}; mul_b = {3'b0, sat_frac(rt_frac)}; end
      default:    ;
    endcase
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = {prod_q[51:0]};
    div_den   = zdiv;
    div_cnt   = 6'd52;
    case (cmd_i.op)
      OP_H_DIV, OP_S_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  slrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .cnt_i   (div_cnt),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // state that reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LayerCount; i++) lvl_q[i] <= '0;
      for (int i = 0; i < 5; i++) store_q[i] <= '0;
      out_valid_q <= 1'b0;
      cfg_c_q     <= 17'd65536;
      cfg_h_q     <= '0;
      cfg_d_q     <= '0;
      cfg_s_q     <= '0;
      cfg_depth_q <= 29'd65536000;
      cfg_surf_q  <= '0;
      cfg_inter_q <= '0;
      cfg_gw_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_EVAP_DECAY:    cfg_c_q     <= cfg_data_i[16:0];
          CFG_QUICK_RUNOFF:  cfg_h_q     <= cfg_data_i[16:0];
          CFG_DRAIN_FRAC:    cfg_d_q     <= cfg_data_i[16:0];
          CFG_SOIL_OUTFLOW:  cfg_s_q     <= cfg_data_i[16:0];
          CFG_SOIL_DEPTH:    cfg_depth_q <= cfg_data_i;
          CFG_SURFACE_ROUTE: cfg_surf_q  <= cfg_data_i[16:0];
          CFG_INTER_ROUTE:   cfg_inter_q <= cfg_data_i[16:0];
          CFG_GW_ROUTE:      cfg_gw_q    <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_FILL: lvl_q[cmd_i.idx] <= fill_lvl;
        OP_L1_SET, OP_L2_SET, OP_L3_SET:
          if (leak_ok) lvl_q[cmd_i.idx] <= lvl_cur - leak[31:0];
        OP_EV_SET: lvl_q[cmd_i.idx] <= ev_cover ? lvl_cur - {7'b0, deficit_q} : '0;
        OP_RT_SET: store_q[cmd_i.idx] <= rt_new;
        default: ;
      endcase
    end
  end

  // per item working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_LOAD: begin
        surplus_q <= rain_ge_pet;
        total_q   <= lvl_sum;
        excess_q  <= {8'b0, rain_c - {2'b0, in_i.pet_depth}};
        deficit_q <= 25'({2'b0, in_i.pet_depth} - rain_c);
        aeva_q    <= rain_ge_pet ? {10'b0, in_i.pet_depth} : {8'b0, rain_c};
        to_ove_q  <= '0;
        to_dra_q  <= '0;
        to_int_q  <= '0;
        to_sgw_q  <= '0;
        to_dgw_q  <= '0;
      end
      OP_CAP_SET: cap_q <= cap_prod[59:33];
      OP_H_SET:   hp_q <= (div_quot > {35'b0, ONE_Q16}) ? ONE_Q16 : div_quot[16:0];
      OP_OVE_SET: begin
        to_ove_q <= prod_q[42:16];
        excess_q <= excess_q - {8'b0, prod_q[42:16]};
      end
      OP_FILL:    excess_q <= fill_excess;
      OP_DRA_SET: begin
        to_dra_q <= prod_q[50:16];
        to_int_q <= {2'b0, excess_q - prod_q[50:16]};
      end
      OP_S_SET:   sp_q <= (div_quot > {32'b0, SP_MAX}) ? SP_MAX : div_quot[19:0];
      OP_PW_SET:  pw_q[cmd_i.idx] <= (prod_q[39:16] > {4'b0, SP_MAX}) ? SP_MAX
                                                                      : prod_q[35:16];
      OP_L1_SET:  if (leak_ok) to_int_q <= to_int_q + {1'b0, leak};
      OP_L2_DIV:  spq_q <= sp_recip[42:23];
      OP_L2_SET:  if (leak_ok) to_sgw_q <= to_sgw_q + leak[34:0];
      OP_L3_SET:  if (leak_ok) to_dgw_q <= to_dgw_q + leak[34:0];
      OP_EV_SET: begin
        if (ev_cover) begin
          aeva_q    <= aeva_q + {10'b0, deficit_q};
          deficit_q <= '0;
        end else begin
          aeva_q    <= aeva_q + {3'b0, lvl_cur};
          deficit_q <= prod_q[40:16];
        end
      end
      OP_RT_SET:  rel_q[cmd_i.idx] <= prod_q[47:16];
      OP_FINISH: begin
        out_q.actual_evap   <= sat29({3'b0, aeva_q});
        out_q.overland_flow <= sat29({6'b0, rel_q[0]});
        out_q.drain_flow    <= sat29({6'b0, rel_q[1]});
        out_q.inter_flow    <= sat29({6'b0, rel_q[2]});
        out_q.shallow_flow  <= sat29({6'b0, rel_q[3]});
        out_q.deep_flow     <= sat29({6'b0, rel_q[4]});
        out_q.soil_moisture <= sat29({3'b0, lvl_sum});
      end
      default: ;
    endcase
  end

  assign status_o.surplus  = surplus_q;
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_FINISH |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_quot_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_CAP_SET || cmd_i.op == OP_H_SET || cmd_i.op == OP_S_SET
     || cmd_i.op == OP_L2_MUL) |-> !div_busy)
    else $error("quotient used before divider finished");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_FINISH |=> out_valid_q)
    else $error("result not presented after finish");

endmodule
